### src/trapezoidal_velocity_profile_assert.svh
// Assertion macros for the trapezoidal velocity profile RTL.
`ifndef TRAPEZOIDAL_VELOCITY_PROFILE_ASSERT_SVH
`define TRAPEZOIDAL_VELOCITY_PROFILE_ASSERT_SVH

// Property must hold on every clock outside reset.
`define TVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define TVP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/tvp_pkg.sv
// Shared widths, unit status type and helpers for the velocity profile block.
package tvp_pkg;

  localparam int DIV_NW = 64;  // dividend / quotient width
  localparam int DIV_DW = 32;  // divisor width
  localparam int MUL_W  = 32;  // multiplier operand width
  localparam int SQ_XW  = 64;  // square root radicand width
  localparam int SQ_RW  = 32;  // square root result width

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic [31:0] sat32(input logic [63:0] x);
    logic [31:0] r;
    r = (x > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    return r;
  endfunction

endpackage

### src/tvp_div.sv
// Restoring divider, one quotient bit per cycle.
module tvp_div import tvp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic [DIV_NW-1:0] quo_o,
  output unit_sts_t         sts_o
);
  localparam int CW = $clog2(DIV_NW);

  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] rem_q, rem_d, den_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;
  logic [DIV_DW:0]   trial, diff;
  logic              fits;

  always_comb begin
    trial = {rem_q, quo_q[DIV_NW-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    quo_d = {quo_q[DIV_NW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o      = quo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
endmodule

### src/tvp_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
module tvp_mul import tvp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_W-1:0]   a_i,
  input  logic [MUL_W-1:0]   b_i,
  output logic [2*MUL_W-1:0] prod_o,
  output unit_sts_t          sts_o
);
  localparam int CW = $clog2(MUL_W);

  logic [2*MUL_W-1:0] prod_q, prod_d;
  logic [MUL_W-1:0]   a_q;
  logic [MUL_W:0]     sum;
  logic [CW-1:0]      cnt_q;
  logic               busy_q, done_q;

  always_comb begin
    sum    = {1'b0, prod_q[2*MUL_W-1:MUL_W]} + (prod_q[0] ? {1'b0, a_q} : '0);
    prod_d = {sum, prod_q[MUL_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(MUL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      prod_q <= {{MUL_W{1'b0}}, b_i};
      a_q    <= a_i;
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o     = prod_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
endmodule

### src/tvp_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module tvp_sqrt import tvp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SQ_XW-1:0] x_i,
  output logic [SQ_RW-1:0] root_o,
  output unit_sts_t        sts_o
);
  localparam int CW = $clog2(SQ_RW);

  logic [SQ_XW-1:0] x_q;
  logic [SQ_RW+1:0] rem_q, rem_d;
  logic [SQ_RW-1:0] root_q, root_d;
  logic [SQ_RW+3:0] rsh, trial, diff;
  logic             ge;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;

  always_comb begin
    rsh    = {rem_q, x_q[SQ_XW-1:SQ_XW-2]};
    trial  = {2'b00, root_q, 2'b01};
    diff   = rsh - trial;
    ge     = rsh >= trial;
    rem_d  = ge ? diff[SQ_RW+1:0] : rsh[SQ_RW+1:0];
    root_d = {root_q[SQ_RW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(SQ_RW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      x_q    <= x_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[SQ_XW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o     = root_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
endmodule

### src/trapezoidal_velocity_profile.sv
// Top level: trapezoidal velocity profile sequencer with serial arithmetic units.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------------
//  in      | in  | in_valid_i/in_ready_o  | restart_i
//  out     | out | out_valid_o/out_ready_i| velocity_o sample_time_o last_o finished_o
//  cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index_i cfg_data_i
//
//  Idle item (no restart, profile over): goes straight to ST_OUT, then into the output register once it is free.
//  Tick: one 64-step division for the tick time and a 32-step multiply for the ramp
//  velocity; cruise skips the multiply.
//  Restart: planning first, longer for a triangle than for a trapezoid, using the
//  serial divider, multiplier and square root in turn.
//  Reset clears control and restores register defaults; the block comes up idle.
//  A result waits in the output register while the next item is taken in; the
//  sequencer stalls only when a new result finds that register still full.
module trapezoidal_velocity_profile import tvp_pkg::*; #(
  parameter int FRAC_BITS        = 16,
  parameter int TICKS_PER_SECOND = 100
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] velocity_o,
  output logic        [31:0] sample_time_o,
  output logic               last_o,
  output logic               finished_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [1:0]  cfg_index_i,
  input  logic        [31:0] cfg_data_i
);
`include "trapezoidal_velocity_profile_assert.svh"

  localparam logic [30:0] RATE_RST = 31'(1) << FRAC_BITS;
  localparam logic [31:0] TPS      = 32'(TICKS_PER_SECOND);
  localparam logic [63:0] TPS_HALF = 64'(TICKS_PER_SECOND / 2);

  // register indexes
  localparam logic [1:0] CFG_DIST  = 2'd0;
  localparam logic [1:0] CFG_VLIM  = 2'd1;
  localparam logic [1:0] CFG_ACCEL = 2'd2;
  localparam logic [1:0] CFG_DECEL = 2'd3;

  // sequencer states
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_VV     = 5'd1;   // v*v
  localparam logic [4:0] ST_DA     = 5'd2;   // v*v/2a
  localparam logic [4:0] ST_DD     = 5'd3;   // v*v/2d, then pick shape
  localparam logic [4:0] ST_TR_UP  = 5'd4;
  localparam logic [4:0] ST_TR_DN  = 5'd5;
  localparam logic [4:0] ST_TR_CR  = 5'd6;
  localparam logic [4:0] ST_TA_MA  = 5'd7;   // triangle: dist*a
  localparam logic [4:0] ST_TA_DA  = 5'd8;
  localparam logic [4:0] ST_TA_MD  = 5'd9;
  localparam logic [4:0] ST_TA_DD  = 5'd10;
  localparam logic [4:0] ST_TA_QU  = 5'd11;
  localparam logic [4:0] ST_TA_SU  = 5'd12;
  localparam logic [4:0] ST_TA_QD  = 5'd13;
  localparam logic [4:0] ST_TA_SD  = 5'd14;
  localparam logic [4:0] ST_TA_PK  = 5'd15;
  localparam logic [4:0] ST_TK_DIV = 5'd16;  // time at end of tick
  localparam logic [4:0] ST_TK_MUL = 5'd17;  // ramp velocity
  localparam logic [4:0] ST_TK_FIN = 5'd18;
  localparam logic [4:0] ST_OUT    = 5'd19;

  logic [4:0]  state_q;
  logic        go_q;

  // configuration
  logic [31:0] dist_q;
  logic [30:0] vlim_q, acc_q, dec_q;

  // profile state
  logic [31:0] tick_q, tk_q, nxt_q;
  logic [31:0] rup_q, cru_q, rdn_q, peak_q, vel_q;
  logic [63:0] da_q, dd_q;
  logic        rev_q, idle_q;

  // pending result and output register
  logic [31:0] res_vel_q, res_time_q;
  logic        res_last_q, res_fin_q;
  logic        out_valid_q;
  logic [31:0] out_vel_q, out_time_q;
  logic        out_last_q, out_fin_q;

  // unit ports
  logic              mul_start, div_start, sqrt_start;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [63:0]       mul_p;
  logic [DIV_NW-1:0] div_n, div_q;
  logic [DIV_DW-1:0] div_d;
  logic [SQ_XW-1:0]  sqrt_x;
  logic [SQ_RW-1:0]  sqrt_r;
  unit_sts_t         mul_sts, div_sts, sqrt_sts;
  logic [2:0]        unit_done_vec;
  logic              unit_done, any_busy, idle_take, out_load;

  // derived operands
  logic [31:0] v32, a32, d32, mag, ad32, ce32, total32;
  logic        rev_c, run, in_up, in_cr;
  logic [33:0] sum_uc, sum_all;
  logic [63:0] pr_sh;

  always_comb begin
    v32     = (vlim_q == '0) ? 32'd1 : {1'b0, vlim_q};
    a32     = (acc_q == '0) ? 32'd1 : {1'b0, acc_q};
    d32     = (dec_q == '0) ? 32'd1 : {1'b0, dec_q};
    ad32    = a32 + d32;
    rev_c   = dist_q[31];
    mag     = rev_c ? (32'd0 - dist_q) : dist_q;
    sum_uc  = {2'b00, rup_q} + {2'b00, cru_q};
    sum_all = sum_uc + {2'b00, rdn_q};
    ce32    = sat32(64'(sum_uc));
    total32 = sat32(64'(sum_all));
    run     = tk_q < total32;
    in_up   = tk_q < rup_q;
    in_cr   = tk_q < ce32;
    pr_sh   = mul_p >> FRAC_BITS;
  end

  // operand steering per state
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    div_n  = '0;
    div_d  = 32'd1;
    sqrt_x = div_q;
    case (state_q)
      ST_VV:     begin mul_a = v32; mul_b = v32; end
      ST_DA:     begin div_n = mul_p; div_d = {a32[30:0], 1'b0}; end
      ST_DD:     begin div_n = mul_p; div_d = {d32[30:0], 1'b0}; end
      ST_TR_UP:  begin div_n = 64'(v32) << FRAC_BITS; div_d = a32; end
      ST_TR_DN:  begin div_n = 64'(v32) << FRAC_BITS; div_d = d32; end
      ST_TR_CR:  begin div_n = (64'(mag) - da_q - dd_q) << FRAC_BITS; div_d = v32; end
      ST_TA_MA:  begin mul_a = mag; mul_b = a32; end
      ST_TA_DA:  begin div_n = mul_p; div_d = ad32; end
      ST_TA_MD:  begin mul_a = mag; mul_b = d32; end
      ST_TA_DD:  begin div_n = mul_p; div_d = ad32; end
      ST_TA_QU:  begin div_n = da_q << (FRAC_BITS + 1); div_d = a32; end
      ST_TA_QD:  begin div_n = dd_q << (FRAC_BITS + 1); div_d = d32; end
      ST_TA_PK:  begin mul_a = a32; mul_b = rup_q; end
      ST_TK_DIV: begin
        div_n = ((64'(tick_q) + 64'd1) << FRAC_BITS) + TPS_HALF;
        div_d = TPS;
      end
      ST_TK_MUL: begin
        mul_a = in_up ? {1'b0, acc_q} : {1'b0, dec_q};
        mul_b = in_up ? tk_q : (tk_q - ce32);
      end
      default: ;
    endcase
  end

  assign mul_start  = !go_q && (state_q == ST_VV || state_q == ST_TA_MA ||
                      state_q == ST_TA_MD || state_q == ST_TA_PK || state_q == ST_TK_MUL);
  assign sqrt_start = !go_q && (state_q == ST_TA_SU || state_q == ST_TA_SD);
  assign div_start  = !go_q && (state_q == ST_DA || state_q == ST_DD ||
                      state_q == ST_TR_UP || state_q == ST_TR_DN || state_q == ST_TR_CR ||
                      state_q == ST_TA_DA || state_q == ST_TA_DD || state_q == ST_TA_QU ||
                      state_q == ST_TA_QD || state_q == ST_TK_DIV);
  assign unit_done_vec = {mul_sts.done, div_sts.done, sqrt_sts.done};
  assign unit_done     = |unit_done_vec;
  assign any_busy      = mul_sts.busy | div_sts.busy | sqrt_sts.busy;

  tvp_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .prod_o(mul_p), .sts_o(mul_sts)
  );

  tvp_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_n), .den_i(div_d),
    .quo_o(div_q), .sts_o(div_sts)
  );

  tvp_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .x_i(sqrt_x),
    .root_o(sqrt_r), .sts_o(sqrt_sts)
  );

  // configuration writes, always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
      vlim_q <= RATE_RST;
      acc_q  <= RATE_RST;
      dec_q  <= RATE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DIST:  dist_q <= cfg_data_i;
        CFG_VLIM:  vlim_q <= cfg_data_i[30:0];
        CFG_ACCEL: acc_q  <= cfg_data_i[30:0];
        CFG_DECEL: dec_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign idle_take  = in_valid_i && in_ready_o && idle_q && !restart_i;

  // pending result moves out when the output register is free or being drained
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      go_q        <= 1'b0;
      idle_q      <= 1'b1;
      rev_q       <= 1'b0;
      tick_q      <= '0;
      tk_q        <= '0;
      nxt_q       <= '0;
      rup_q       <= '0;
      cru_q       <= '0;
      rdn_q       <= '0;
      peak_q      <= '0;
      vel_q       <= '0;
      da_q        <= '0;
      dd_q        <= '0;
      res_vel_q   <= '0;
      res_time_q  <= '0;
      res_last_q  <= 1'b0;
      res_fin_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (restart_i) begin
              rev_q   <= rev_c;
              tick_q  <= '0;
              tk_q    <= '0;
              idle_q  <= 1'b0;
              state_q <= ST_VV;
            end else if (idle_q) begin
              // idling: zero sample, finished set
              res_vel_q  <= '0;
              res_time_q <= '0;
              res_last_q <= 1'b0;
              res_fin_q  <= 1'b1;
              state_q    <= ST_OUT;
            end else begin
              state_q <= ST_TK_DIV;
            end
          end
        end
        ST_TK_FIN: begin
          res_time_q <= nxt_q;
          res_fin_q  <= 1'b0;
          if (run) begin
            res_vel_q  <= rev_q ? (32'd0 - vel_q) : vel_q;
            res_last_q <= 1'b0;
            tk_q       <= nxt_q;
            if (tick_q != 32'hFFFF_FFFF) tick_q <= tick_q + 32'd1;
          end else begin
            // final zero sample
            res_vel_q  <= '0;
            res_last_q <= 1'b1;
            idle_q     <= 1'b1;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) state_q <= ST_IDLE;
        end
        default: begin
          if (!go_q) begin
            go_q <= 1'b1;
          end else if (unit_done) begin
            go_q <= 1'b0;
            case (state_q)
              ST_VV: state_q <= ST_DA;
              ST_DA: begin da_q <= div_q; state_q <= ST_DD; end
              ST_DD: begin
                dd_q <= div_q;
                // ramps overlap: reduced-peak triangle
                if ({1'b0, da_q} + {1'b0, div_q} > 65'(mag)) state_q <= ST_TA_MA;
                else state_q <= ST_TR_UP;
              end
              ST_TR_UP: begin rup_q <= sat32(div_q); state_q <= ST_TR_DN; end
              ST_TR_DN: begin rdn_q <= sat32(div_q); state_q <= ST_TR_CR; end
              ST_TR_CR: begin
                cru_q   <= sat32(div_q);
                peak_q  <= v32;
                state_q <= ST_TK_DIV;
              end
              ST_TA_MA: state_q <= ST_TA_DA;
              ST_TA_DA: begin da_q <= div_q; state_q <= ST_TA_MD; end
              ST_TA_MD: state_q <= ST_TA_DD;
              ST_TA_DD: begin dd_q <= div_q; state_q <= ST_TA_QU; end
              ST_TA_QU: state_q <= ST_TA_SU;
              ST_TA_SU: begin rup_q <= sqrt_r; state_q <= ST_TA_QD; end
              ST_TA_QD: state_q <= ST_TA_SD;
              ST_TA_SD: begin
                rdn_q   <= sqrt_r;
                cru_q   <= '0;
                state_q <= ST_TA_PK;
              end
              ST_TA_PK: begin
                peak_q  <= (pr_sh > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : pr_sh[31:0];
                state_q <= ST_TK_DIV;
              end
              ST_TK_DIV: begin
                nxt_q <= sat32(div_q);
                if (run && !in_up && in_cr) begin
                  vel_q   <= peak_q;
                  state_q <= ST_TK_FIN;
                end else if (run) begin
                  state_q <= ST_TK_MUL;
                end else begin
                  state_q <= ST_TK_FIN;
                end
              end
              ST_TK_MUL: begin
                if (in_up) begin
                  vel_q <= (pr_sh > 64'(peak_q)) ? peak_q : pr_sh[31:0];
                end else begin
                  vel_q <= (pr_sh >= 64'(peak_q)) ? 32'd0 : (peak_q - pr_sh[31:0]);
                end
                state_q <= ST_TK_FIN;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_vel_q  <= res_vel_q;
      out_time_q <= res_time_q;
      out_last_q <= res_last_q;
      out_fin_q  <= res_fin_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign velocity_o    = out_vel_q;
  assign sample_time_o = out_time_q;
  assign last_o        = out_last_q;
  assign finished_o    = out_fin_q;

  `TVP_ASSERT(a_one_unit_done, $countones(unit_done_vec) <= 1, "two units finished together")
  `TVP_ASSERT(a_idle_fast_path, idle_take |=> state_q == ST_OUT, "idle item not sent straight out")
  `TVP_ASSERT(a_last_is_zero, out_valid_o && last_o |-> velocity_o == 32'sd0, "last sample nonzero")
  `TVP_ASSERT_NEVER(a_idle_units_quiet, state_q == ST_IDLE && any_busy, "unit busy while idle")
endmodule

### verif/trapezoidal_velocity_profile_test.sv
// Testbench for the trapezoidal velocity profile block: config phases, tick stream, scoreboard.
`default_nettype none

module trapezoidal_velocity_profile_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tvp_pkg::*;

  localparam int FRAC = 16;
  localparam int TPS  = 100;

  // register map
  localparam logic [1:0] REG_DISTANCE = 2'd0;
  localparam logic [1:0] REG_VLIMIT   = 2'd1;
  localparam logic [1:0] REG_ACCEL    = 2'd2;
  localparam logic [1:0] REG_DECEL    = 2'd3;

  // no transfer of any kind for this many cycles means the block hung
  localparam int HANG_LIMIT = 6000;
  localparam int HOLD_CYCLES = 800;
  localparam int TOTAL_ITEMS = 1050;

  typedef struct {
    logic [31:0] vel;
    logic [31:0] stamp;
    bit          last;
    bit          fin;
  } sample_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, restart_i;
  logic out_valid_o, out_ready_i;
  logic signed [31:0] velocity_o;
  logic [31:0] sample_time_o;
  logic last_o, finished_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  trapezoidal_velocity_profile DUT (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // shadow registers and profile state of the predictor
  logic [31:0] sh_dist, sh_vlim, sh_acc, sh_dec;
  logic [31:0] pf_tick, pf_up, pf_cruise, pf_down, pf_peak;
  bit          pf_rev, pf_idle;

  bit      pending_restart[$];  // items waiting for the driver
  sample_t expected_samples[$];

  int errors = 0;
  int items_sent = 0;
  int samples_seen = 0;
  int lasts_seen = 0;
  int restarts_sent = 0;
  int phases_run = 0;
  bit hold_request = 0;

  function automatic logic [31:0] clip32(input logic [63:0] x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // time at tick k, rounded, saturating
  function automatic logic [31:0] tick_stamp(input logic [63:0] k);
    return clip32(((k << FRAC) + TPS / 2) / TPS);
  endfunction

  // phase times from the shadow registers; zero rates count as one
  task automatic plan_profile();
    logic [63:0] v, a, d, span, da, dd, up;
    v = (sh_vlim == 0) ? 64'd1 : 64'(sh_vlim);
    a = (sh_acc == 0) ? 64'd1 : 64'(sh_acc);
    d = (sh_dec == 0) ? 64'd1 : 64'(sh_dec);
    pf_rev = sh_dist[31];
    span = pf_rev ? 64'(32'(-sh_dist)) : 64'(sh_dist);
    if (pf_rev && span == 0) span = 64'h8000_0000;
    da = (v * v) / (2 * a);
    dd = (v * v) / (2 * d);
    if (da + dd > span) begin
      // ramps overlap: asymmetric triangle with reduced peak
      da = span * a / (a + d);
      dd = span * d / (a + d);
      pf_up = clip32(int_sqrt(((2 * da) << FRAC) / a));
      pf_down = clip32(int_sqrt(((2 * dd) << FRAC) / d));
      pf_cruise = 0;
      up = (a * 64'(pf_up)) >> FRAC;
      pf_peak = (up > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : up[31:0];
    end else begin
      pf_up = clip32((v << FRAC) / a);
      pf_down = clip32((v << FRAC) / d);
      pf_cruise = clip32(((span - da - dd) << FRAC) / v);
      pf_peak = v[31:0];
    end
  endtask

  // next velocity sample for one accepted item
  task automatic predict_sample(input bit restart);
    sample_t s;
    logic [31:0] tk, total, cruise_end;
    logic [63:0] vel, drop;
    if (restart) begin
      plan_profile();
      pf_tick = 0;
      pf_idle = 0;
    end
    s = '{vel: 0, stamp: 0, last: 0, fin: 1};
    if (!pf_idle) begin
      tk = tick_stamp(64'(pf_tick));
      total = clip32(64'(pf_up) + pf_cruise + pf_down);
      cruise_end = clip32(64'(pf_up) + pf_cruise);
      s.stamp = tick_stamp(64'(pf_tick) + 1);
      s.fin = 0;
      if (tk < total) begin
        if (tk < pf_up) begin
          vel = (64'(sh_acc) * tk) >> FRAC;
          if (vel > pf_peak) vel = pf_peak;
        end else if (tk < cruise_end) begin
          vel = pf_peak;
        end else begin
          drop = (64'(sh_dec) * 64'(tk - cruise_end)) >> FRAC;
          vel = (drop >= pf_peak) ? 0 : pf_peak - drop;
        end
        s.vel = pf_rev ? -vel[31:0] : vel[31:0];
        if (pf_tick != 32'hFFFF_FFFF) pf_tick++;
      end else begin
        s.last = 1;
        pf_idle = 1;
      end
    end
    expected_samples = {expected_samples, s};
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("[%0t] MISMATCH %s: got %h, expected %h (sample %0d)",
             $realtime, what, got, want, samples_seen);
  endtask

  // ------------------------------------------------------------------
  // Input driver: bursts of random length separated by random gaps.
  // The posedge block runs the predictor on every transfer and pops.
  // ------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;
  bit in_fire = 0;

  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_sample(restart_i);
      void'(pending_restart.pop_front());
      items_sent++;
      if (restart_i) restarts_sent++;
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      restart_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      // in_fire marks a transfer at the last rising edge
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_restart.size() != 0) begin
        in_valid_i <= 1'b1;
        restart_i <= pending_restart[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          // about one burst in four runs back to back
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Receiver: random stalls in alternating windows, plus one long
  // hold-off on request so the block backs up into its input.
  // ------------------------------------------------------------------
  int hold_left = 0;
  int cyc = 0;

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (cyc % 4096 < 1024) begin
        out_ready_i <= 1'b1;  // stretch with no stalls
      end else begin
        out_ready_i <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Output monitor: field by field against the oldest expectation
  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      samples_seen++;
      if (expected_samples.size() == 0) begin
        errors++;
        $display("[%0t] MISMATCH unexpected sample, none pending", $realtime);
      end else begin
        want = expected_samples.pop_front();
        if (velocity_o !== want.vel) report_mismatch("velocity", velocity_o, want.vel);
        if (sample_time_o !== want.stamp)
          report_mismatch("sample_time", sample_time_o, want.stamp);
        if (last_o !== want.last) report_mismatch("last", 32'(last_o), 32'(want.last));
        if (finished_o !== want.fin)
          report_mismatch("finished", 32'(finished_o), 32'(want.fin));
        if (want.last) lasts_seen++;
      end
    end
  end

  // Watchdog: cycles without any transfer on any channel
  int quiet = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= HANG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", HANG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // register write; the shadow copy changes on the transfer
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DISTANCE: sh_dist = data;
      REG_VLIMIT:   sh_vlim = {1'b0, data[30:0]};
      REG_ACCEL:    sh_acc = {1'b0, data[30:0]};
      REG_DECEL:    sh_dec = {1'b0, data[30:0]};
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] dist_val, input logic [31:0] vlim,
                           input logic [31:0] acc, input logic [31:0] dec);
    write_reg(REG_DISTANCE, dist_val);
    write_reg(REG_VLIMIT, vlim);
    write_reg(REG_ACCEL, acc);
    write_reg(REG_DECEL, dec);
  endtask

  // queue a restart followed by ticks, with the odd restart mid-profile
  task automatic queue_profile(input int ticks, input int restart_odds);
    pending_restart = {pending_restart, 1'b1};
    repeat (ticks)
      pending_restart = {pending_restart,
                         bit'(restart_odds != 0 && $urandom_range(1, restart_odds) == 1)};
  endtask

  // wait until the block has nothing in flight, then a margin for the sequencer
  task automatic drain();
    wait (pending_restart.size() == 0 && expected_samples.size() == 0);
    repeat (30) @(posedge clk_i);
    phases_run++;
  endtask

  initial begin
    logic [31:0] d, v, a, r;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    restart_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_DISTANCE;
    cfg_data_i = '0;
    sh_dist = 0;
    sh_vlim = 32'h1_0000;
    sh_acc = 32'h1_0000;
    sh_dec = 32'h1_0000;
    pf_tick = 0; pf_up = 0; pf_cruise = 0; pf_down = 0; pf_peak = 0;
    pf_rev = 0; pf_idle = 1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults: ticks before any restart idle, zero distance ends at once
    pending_restart = {pending_restart, 1'b0};
    pending_restart = {pending_restart, 1'b1};
    pending_restart = {pending_restart, 1'b0};
    drain();

    // trapezoid, triangle, backward move
    configure(32'h0003_0000, 32'h0001_0000, 32'h0004_0000, 32'h0004_0000);
    queue_profile(4, 0);
    drain();
    configure(32'h0000_8000, 32'h000A_0000, 32'h0002_0000, 32'h0008_0000);
    queue_profile(3, 0);
    drain();
    configure(32'hFFFD_0000, 32'h0002_0000, 32'h0010_0000, 32'h0020_0000);
    queue_profile(3, 0);
    drain();
    // extremes: most negative distance with full-scale rates, largest distance
    // with the smallest step, and registers written as zero
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_profile(2, 0);
    drain();
    configure(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    queue_profile(2, 0);
    drain();
    configure(32'h0005_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_profile(2, 0);
    drain();

    // random phases; most are short complete moves, some full-range noise
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        d = $urandom();
        v = $urandom();
        a = $urandom();
        r = $urandom();
      end else begin
        d = $urandom_range(1 << 12, 12 << 16);
        if ($urandom_range(0, 1)) d = -d;
        v = $urandom_range(1 << 14, 6 << 16);
        a = $urandom_range(6 << 16, 64 << 16);
        r = $urandom_range(6 << 16, 64 << 16);
      end
      configure(d, v, a, r);
      if (phases_run == 10) hold_request = 1;
      queue_profile($urandom_range(20, 90), 40);
      drain();
    end

    $display("run covered %0d phases, %0d items (%0d restarts), %0d samples, %0d moves ended",
             phases_run, items_sent, restarts_sent, samples_seen, lasts_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d field mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+src
src/tvp_pkg.sv
src/tvp_div.sv
src/tvp_mul.sv
src/tvp_sqrt.sv
src/trapezoidal_velocity_profile.sv
verif/trapezoidal_velocity_profile_test.sv
